/* rtl/lcm_pkg.sv */
// Shared types and constants of the four-axis step generator.
`default_nettype none
package lcm_pkg;
	localparam int STEP_W    = 16;
	localparam int CNT_W     = STEP_W + 1;
	localparam int AXES      = 4;
	localparam int WIDE_W    = 2 * STEP_W;
	localparam int SHIFT_W   = $clog2(STEP_W);
	localparam int DIV_CNT_W = $clog2(STEP_W + 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_BUSY     = 2'd2
	} status_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [AXES-1:0][STEP_W-1:0] tot;
	} cmd_t;

	typedef struct packed {
		logic [AXES-1:0] step;
		logic            done;
		logic [STEP_W-1:0] tick_total;
		status_t         status;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE, B_GCD_INIT, B_GCD_RUN, B_DIV_RUN, B_MUL, B_NEXT,
		B_DIV_INIT, B_DIV_STORE, B_OUT
	} bstate_t;
endpackage
`default_nettype wire

/* rtl/lcm_front.sv */
// Front end: two-entry command queue with input stall.
`default_nettype none
module lcm_front import lcm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire cmd_t in_cmd,
	output logic      q_valid,
	input  wire logic q_pop,
	output cmd_t      q_cmd
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

/* rtl/lcm_back.sv */
// Back end: LCM and reload calculation, axis counters and result register.
`default_nettype none
module lcm_back import lcm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_pop,
	input  wire cmd_t q_cmd,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_res
);
	bstate_t st_q, st_n;
	logic [CNT_W-1:0] rf_q [AXES];
	logic [CNT_W-1:0] ac_q [AXES];
	logic [STEP_W-1:0] left_q;
	logic active_q;
	logic ovf_q;
	logic [1:0] phase_q;       // 0: X,Y  1: Z,E  2: pair results  3: reload factors
	logic [1:0] ax_q;
	logic [STEP_W-1:0] opa_q, opb_q, p1_q;
	logic [STEP_W-1:0] ga_q, gb_q;
	logic [SHIFT_W-1:0] gk_q;
	logic [WIDE_W-1:0] acc_q;
	logic [STEP_W-1:0] rem_q, quo_q, dvs_q;
	logic [DIV_CNT_W-1:0] bit_q;
	logic [STEP_W+1:0] trial;
	logic [STEP_W-1:0] pair_a, pair_b;
	logic [CNT_W-1:0] reload;
	logic gcd_done, div_done, wide;
	res_t res_n;
	logic res_load;

	assign gcd_done = (ga_q == gb_q);
	assign div_done = (bit_q == '0);
	assign wide = (acc_q[WIDE_W-1:STEP_W] != '0);
	assign trial = {1'b0, rem_q, quo_q[STEP_W-1]} - {2'b00, dvs_q};
	assign reload = (q_cmd.tot[ax_q] == '0) ?
	                CNT_W'(acc_q[STEP_W-1:0]) + CNT_W'(1) : {1'b0, quo_q};

	// operands of the current pass, a zero total counts as one
	always_comb begin
		if (phase_q == 2'd2) begin
			pair_a = p1_q;
			pair_b = acc_q[STEP_W-1:0];
		end else begin
			pair_a = q_cmd.tot[{phase_q[0], 1'b0}];
			pair_b = q_cmd.tot[{phase_q[0], 1'b1}];
			if (pair_a == '0) pair_a = STEP_W'(1);
			if (pair_b == '0) pair_b = STEP_W'(1);
		end
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			B_IDLE: if (q_valid && !(out_valid && out_stall)) begin
				if (q_cmd.op == OP_LOAD && !active_q) st_n = B_GCD_INIT;
				else st_n = B_OUT;
			end
			B_GCD_INIT: st_n = B_GCD_RUN;
			B_GCD_RUN:  if (gcd_done) st_n = B_DIV_RUN;
			B_DIV_RUN:  if (div_done) st_n = (phase_q == 2'd3) ? B_DIV_STORE : B_MUL;
			B_MUL:      st_n = B_NEXT;
			B_NEXT: begin
				if (wide) st_n = B_OUT;
				else if (phase_q == 2'd2) st_n = B_DIV_INIT;
				else st_n = B_GCD_INIT;
			end
			B_DIV_INIT: st_n = B_DIV_RUN;
			B_DIV_STORE: st_n = (ax_q == 2'(AXES-1)) ? B_OUT : B_DIV_INIT;
			B_OUT:      st_n = B_IDLE;
			default:    st_n = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (st_q == B_OUT);
		res_load = (st_q == B_OUT);
		res_n = '0;
		if (q_cmd.op == OP_TICK) begin
			if (active_q) begin
				for (int i = 0; i < AXES; i++)
					res_n.step[i] = (ac_q[i] == CNT_W'(1));
				res_n.done = (left_q == STEP_W'(1));
			end
		end else if (active_q) begin
			res_n.status = ST_BUSY;
		end else if (ovf_q) begin
			res_n.status = ST_OVERFLOW;
		end else begin
			res_n.tick_total = acc_q[STEP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				phase_q <= 2'd0;
				ax_q <= 2'd0;
			end
			B_GCD_INIT: begin
				opa_q <= pair_a; opb_q <= pair_b;
				ga_q <= pair_a; gb_q <= pair_b;
				gk_q <= '0;
			end
			B_GCD_RUN: begin
				// binary gcd; on completion divide the first operand by it
				if (gcd_done) begin
					rem_q <= '0;
					quo_q <= opa_q;
					dvs_q <= ga_q << gk_q;
					bit_q <= DIV_CNT_W'(STEP_W);
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + SHIFT_W'(1);
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (ga_q > gb_q) begin
					ga_q <= (ga_q - gb_q) >> 1;
				end else begin
					gb_q <= (gb_q - ga_q) >> 1;
				end
			end
			B_DIV_RUN: begin
				if (!div_done) begin
					if (!trial[STEP_W+1]) rem_q <= trial[STEP_W-1:0];
					else rem_q <= {rem_q[STEP_W-2:0], quo_q[STEP_W-1]};
					quo_q <= {quo_q[STEP_W-2:0], !trial[STEP_W+1]};
					bit_q <= bit_q - DIV_CNT_W'(1);
				end
			end
			B_MUL: acc_q <= {{STEP_W{1'b0}}, quo_q} * {{STEP_W{1'b0}}, opb_q};
			B_NEXT: begin
				if (phase_q == 2'd0) p1_q <= acc_q[STEP_W-1:0];
				phase_q <= phase_q + 2'd1;
			end
			B_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= acc_q[STEP_W-1:0];
				dvs_q <= q_cmd.tot[ax_q];
				bit_q <= DIV_CNT_W'(STEP_W);
			end
			B_DIV_STORE: ax_q <= ax_q + 2'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			active_q <= 1'b0;
			ovf_q <= 1'b0;
			left_q <= '0;
			out_valid <= 1'b0;
			out_res <= '0;
			for (int i = 0; i < AXES; i++) begin
				rf_q[i] <= '0; ac_q[i] <= '0;
			end
		end else begin
			st_q <= st_n;
			if (st_q == B_IDLE) ovf_q <= 1'b0;
			// a pass result above 16 bits means the final multiple is too
			if (st_q == B_NEXT && wide) ovf_q <= 1'b1;
			if (st_q == B_DIV_STORE) begin
				rf_q[ax_q] <= reload;
				ac_q[ax_q] <= reload;
			end
			if (res_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (res_load) begin
				out_res <= res_n;
				if (q_cmd.op == OP_TICK && active_q) begin
					for (int i = 0; i < AXES; i++)
						ac_q[i] <= (ac_q[i] == CNT_W'(1)) ? rf_q[i] : ac_q[i] - CNT_W'(1);
					left_q <= left_q - STEP_W'(1);
					if (left_q == STEP_W'(1)) active_q <= 1'b0;
				end else if (q_cmd.op == OP_LOAD && !active_q && !ovf_q) begin
					active_q <= 1'b1;
					left_q <= acc_q[STEP_W-1:0];
				end
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/lcm_multi_axis_step_generator.sv */
// Top level of the four-axis step generator.
// Usage:
//   Input channel (in_valid/in_stall): operation plus four 16-bit step totals.
//   operation 0 loads a move, 1 is one timing tick.
//   Output channel (out_valid/out_stall): one result item per input item, in order.
// Item handling:
//   A tick, or a load refused as busy, goes from the head of the queue
//   through B_IDLE and B_OUT into the result register; the back end ends
//   one item before it takes the next.
//   A load runs three gcd/divide/multiply passes and four 16-step restoring
//   divisions for the reload factors in one shared divider.
//   A load that overflows stops after the pass that first exceeds 16 bits.
// A two-entry queue sits between the front and the back, so the input side
// keeps accepting while a result waits, until both entries are full.
// Reset clears the axis counters, the move state and both channels.
// While out_stall is high the result holds and the back end waits.
`default_nettype none
module lcm_multi_axis_step_generator import lcm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              operation,
	input  wire logic [STEP_W-1:0] x_steps,
	input  wire logic [STEP_W-1:0] y_steps,
	input  wire logic [STEP_W-1:0] z_steps,
	input  wire logic [STEP_W-1:0] e_steps,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   step_x,
	output logic                   step_y,
	output logic                   step_z,
	output logic                   step_e,
	output logic                   move_done,
	output logic [STEP_W-1:0]      tick_total,
	output logic [1:0]             status
);
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_pop;
	res_t res;

	assign in_cmd.op = op_t'(operation);
	assign in_cmd.tot = {e_steps, z_steps, y_steps, x_steps};

	lcm_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_cmd,
		.q_valid, .q_pop, .q_cmd
	);

	lcm_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd,
		.out_valid, .out_stall, .out_res(res)
	);

	assign step_x = res.step[0];
	assign step_y = res.step[1];
	assign step_z = res.step[2];
	assign step_e = res.step[3];
	assign move_done = res.done;
	assign tick_total = res.tick_total;
	assign status = res.status;
endmodule
`default_nettype wire

/* rtl/lcm_checker.sv */
// Port-level checker for the step generator, bound to the top level.
`default_nettype none
module lcm_checker import lcm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic step_x,
	input wire logic step_y,
	input wire logic step_z,
	input wire logic step_e,
	input wire logic move_done,
	input wire logic [STEP_W-1:0] tick_total,
	input wire logic [1:0] status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tick_total) && $stable(status))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK || tick_total != '0) |->
		!move_done && !step_x && !step_y && !step_z && !step_e)
		else $error("load result with tick fields");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> tick_total == '0)
		else $error("rejected load with tick count");
endmodule

bind lcm_multi_axis_step_generator lcm_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .step_x, .step_y, .step_z, .step_e,
	.move_done, .tick_total, .status
);
`default_nettype wire
